// ----- design/msie_pkg.sv -----
// ----------------------------------------------------------------------------
// msie_pkg: shared types and constants
// Request codes, opcode/funct encodings and the result bundle passed from the
// execute unit to the top level.
// ----------------------------------------------------------------------------
package msie_pkg;

    localparam int XLEN   = 32;
    localparam int RIDX_W = 5;

    typedef logic [XLEN-1:0]   t_word;
    typedef logic [RIDX_W-1:0] t_ridx;

    // request types
    localparam logic [1:0] REQ_EXEC  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_START = 2'd2;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_JAL     = 6'h03;

    // SPECIAL funct codes
    localparam logic [5:0] FN_ADD = 6'h20;
    localparam logic [5:0] FN_SLL = 6'h00;
    localparam logic [5:0] FN_SRL = 6'h02;
    localparam logic [5:0] FN_JR  = 6'h08;

    localparam t_word RESET_PC = 32'h0040_0000;
    localparam t_ridx LINK_REG = 5'd31;
    localparam t_ridx ZERO_REG = 5'd0;

    typedef struct packed {
        t_word npc;
        logic  wr;
        t_ridx widx;
        t_word wval;
        t_word rval;
    } t_res;

endpackage

// ----- design/msie_ram.sv -----
// ----------------------------------------------------------------------------
// msie_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module msie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/msie_exec.sv -----
// ----------------------------------------------------------------------------
// msie_exec: instruction decode and execute
// Combinational decode of one request against the operands and PC; yields
// the next PC, the register write and the read-back value.
// ----------------------------------------------------------------------------
module msie_exec (
    input  logic [1:0]          i_req,
    input  msie_pkg::t_word     i_instr,
    input  msie_pkg::t_word     i_pc,
    input  msie_pkg::t_word     i_start_addr,
    input  msie_pkg::t_word     i_opa,
    input  msie_pkg::t_word     i_opb,
    output msie_pkg::t_res      o_res
);
    import msie_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    t_ridx       rt;
    t_ridx       rd;
    logic [4:0]  sa;
    logic [15:0] imm;
    t_word       simm;
    t_word       p4;
    t_word       btgt;
    t_word       sum;
    logic        wr;
    t_ridx       widx;
    t_word       wval;
    t_word       npc;

    assign op   = i_instr[31:26];
    assign rt   = i_instr[20:16];
    assign rd   = i_instr[15:11];
    assign sa   = i_instr[10:6];
    assign fn   = i_instr[5:0];
    assign imm  = i_instr[15:0];
    assign simm = {{16{imm[15]}}, imm};
    assign p4   = i_pc + 32'd4;
    assign btgt = p4 + {simm[29:0], 2'b00};
    // shared adder for ADD and ADDI
    assign sum  = i_opa + ((op == OP_SPECIAL) ? i_opb : simm);

    always_comb begin
        wr   = 1'b0;
        widx = ZERO_REG;
        wval = '0;
        npc  = p4;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_ADD: begin wr = 1'b1; widx = rd; wval = sum; end
                    FN_SRL: begin wr = 1'b1; widx = rd; wval = i_opb >> sa; end
                    FN_SLL: begin wr = 1'b1; widx = rd; wval = i_opb << sa; end
                    FN_JR:  npc = i_opa;
                    default: ;
                endcase
            end
            OP_ADDI: begin wr = 1'b1; widx = rt; wval = sum; end
            OP_ANDI: begin wr = 1'b1; widx = rt; wval = i_opa & {16'd0, imm}; end
            OP_BLEZ: begin
                if (i_opa == '0 || i_opa[XLEN-1]) begin
                    npc = btgt;
                end
            end
            OP_BNE: begin
                if (i_opa != i_opb) begin
                    npc = btgt;
                end
            end
            OP_JAL: begin
                wr   = 1'b1;
                widx = LINK_REG;
                wval = p4;
                npc  = {p4[31:28], i_instr[25:0], 2'b00};
            end
            default: ;
        endcase
    end

    always_comb begin
        o_res = '0;
        case (i_req)
            REQ_EXEC: begin
                // writes to r0 are dropped
                o_res.npc  = npc;
                o_res.wr   = wr && (widx != ZERO_REG);
                o_res.widx = o_res.wr ? widx : ZERO_REG;
                o_res.wval = o_res.wr ? wval : '0;
            end
            REQ_READ: begin
                o_res.npc  = i_pc;
                o_res.rval = i_opa;
            end
            REQ_START: o_res.npc = i_start_addr;
            default:   o_res.npc = i_pc;
        endcase
    end

endmodule

// ----- design/mips_subset_instruction_executor.sv -----
// ----------------------------------------------------------------------------
// mips_subset_instruction_executor: MIPS32 subset executor
// RAM register file; one request per clock unless stalled; result in a reg.
// ----------------------------------------------------------------------------
// Each accepted beat (execute, register read or start) produces exactly one
// result beat. A new request is taken every cycle while the result side
// keeps up; the request is registered into the execute stage on its
// accepting edge and its result into the result register when that stage
// advances. On the accept edge rs (or read_index) and rt address two
// copies of the register file RAM; in the next cycle the execute unit works
// on the registered read data, and the register write, PC update and
// result register load happen together when the execute stage advances.
// A write landing on the same edge as a following read is forwarded from a
// last-write register. Registers read as zero until first written, tracked
// by per-entry valid flops, so no clearing pass is needed after reset.
// start_address may only be written while no request is in flight.
// ----------------------------------------------------------------------------
module mips_subset_instruction_executor #(
    parameter int REG_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_instr_word,
    input  logic [4:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic [31:0] o_read_value
);
    import msie_pkg::*;

    t_word                 r_start_addr;
    t_word                 r_pc;
    logic [REG_COUNT-1:0]  r_vld;

    // execute stage
    logic                  r_s1_vld;
    logic [1:0]            r_s1_req;
    t_word                 r_s1_instr;
    t_ridx                 r_a_idx;
    t_ridx                 r_b_idx;
    logic                  r_a_vld;
    logic                  r_b_vld;

    // last register write, for forwarding
    logic                  r_wb_vld;
    t_ridx                 r_wb_idx;
    t_word                 r_wb_val;

    // result register
    logic                  r_o_vld;
    t_res                  r_o_res;

    logic                  in_acc;
    logic                  s1_adv;
    t_ridx                 addr_a;
    t_ridx                 addr_b;
    t_word                 ram_a;
    t_word                 ram_b;
    t_word                 opa;
    t_word                 opb;
    t_res                  res;
    logic                  rf_we;

    assign s1_adv  = r_s1_vld && (!r_o_vld || !i_stall);
    assign o_stall = r_s1_vld && !s1_adv;
    assign in_acc  = i_valid && !o_stall;
    assign rf_we   = s1_adv && res.wr;

    assign addr_a = (i_req_type == REQ_READ) ? i_read_index : i_instr_word[25:21];
    assign addr_b = i_instr_word[20:16];

    msie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_a (
        .i_clk     (i_clk),
        .i_wr_en   (rf_we),
        .i_wr_addr (res.widx),
        .i_wr_data (res.wval),
        .i_rd_en   (in_acc),
        .i_rd_addr (addr_a),
        .o_rd_data (ram_a)
    );

    msie_ram #(.WIDTH(XLEN), .DEPTH(REG_COUNT)) u_rf_b (
        .i_clk     (i_clk),
        .i_wr_en   (rf_we),
        .i_wr_addr (res.widx),
        .i_wr_data (res.wval),
        .i_rd_en   (in_acc),
        .i_rd_addr (addr_b),
        .o_rd_data (ram_b)
    );

    // r_wb always holds the newest write, so matching it is always safe
    assign opa = (r_wb_vld && r_wb_idx == r_a_idx) ? r_wb_val :
                 (r_a_vld ? ram_a : '0);
    assign opb = (r_wb_vld && r_wb_idx == r_b_idx) ? r_wb_val :
                 (r_b_vld ? ram_b : '0);

    msie_exec u_exec (
        .i_req        (r_s1_req),
        .i_instr      (r_s1_instr),
        .i_pc         (r_pc),
        .i_start_addr (r_start_addr),
        .i_opa        (opa),
        .i_opb        (opb),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_addr <= RESET_PC;
            r_pc         <= RESET_PC;
            r_vld        <= '0;
            r_s1_vld     <= 1'b0;
            r_wb_vld     <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_start_addr <= i_cfg_wr_data;
            end
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_pc    <= res.npc;
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
            if (rf_we) begin
                r_vld[res.widx] <= 1'b1;
                r_wb_vld        <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req   <= i_req_type;
            r_s1_instr <= i_instr_word;
            r_a_idx    <= addr_a;
            r_b_idx    <= addr_b;
            r_a_vld    <= r_vld[addr_a];
            r_b_vld    <= r_vld[addr_b];
        end
        if (rf_we) begin
            r_wb_idx <= res.widx;
            r_wb_val <= res.wval;
        end
        if (s1_adv) begin
            r_o_res <= res;
        end
    end

    assign o_valid       = r_o_vld;
    assign o_next_pc     = r_o_res.npc;
    assign o_reg_written = r_o_res.wr;
    assign o_dest_index  = r_o_res.widx;
    assign o_dest_value  = r_o_res.wval;
    assign o_read_value  = r_o_res.rval;

endmodule

// ----- design/msie_checker.sv -----
// ----------------------------------------------------------------------------
// msie_checker: port-level checks for the executor
// Watches the top-level ports only; bound to every instance of the top level.
// ----------------------------------------------------------------------------
module msie_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_next_pc,
    input logic        o_reg_written,
    input logic [4:0]  o_dest_index,
    input logic [31:0] o_dest_value,
    input logic [31:0] o_read_value
);

    a_rst_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_pc)
            && $stable(o_dest_value) && $stable(o_read_value))
        else $error("stalled result beat changed");

    // input backpressure only comes from a stalled, full result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    a_no_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_reg_written |-> o_dest_index == 5'd0 && o_dest_value == 32'd0)
        else $error("dest fields set without a register write");

    a_write_not_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_written |-> o_dest_index != 5'd0 && o_read_value == 32'd0)
        else $error("bad register write beat");

endmodule

bind mips_subset_instruction_executor msie_checker u_msie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_next_pc     (o_next_pc),
    .o_reg_written (o_reg_written),
    .o_dest_index  (o_dest_index),
    .o_dest_value  (o_dest_value),
    .o_read_value  (o_read_value)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for mips_subset_instruction_executor
// Drives execute, register read, start and unused request beats with random
// idle and stall bursts. A scoreboard class keeps its own copy of the
// register file, PC and start address, predicts each result when the request
// beat is accepted, and checks every result beat in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msie_pkg::*;

    localparam logic [1:0] REQ_NONE  = 2'd3;  // unused request code, no effect
    localparam logic [5:0] FN_UNUSED = 6'h3F;

    class exec_scoreboard;
        t_word gpr [32];
        t_word pc;
        t_word start_addr;
        t_res  pending_results [$];
        int    fails;

        function new();
            foreach (gpr[i]) gpr[i] = '0;
            pc         = RESET_PC;
            start_addr = RESET_PC;
            fails      = 0;
        endfunction

        function t_word gpr_read(t_ridx n);
            return (n == ZERO_REG) ? '0 : gpr[n];
        endfunction

        // Advance the model by one accepted request beat; queue its result.
        function void note_request(logic [1:0] req, t_word w, t_ridx ridx);
            t_res       r;
            t_word      a;
            t_word      b;
            t_word      p4;
            t_word      npc;
            t_word      boff;
            logic [5:0] op;
            logic [5:0] fn;
            r = '0;
            case (req)
                REQ_EXEC: begin
                    op   = w[31:26];
                    fn   = w[5:0];
                    a    = gpr_read(w[25:21]);
                    b    = gpr_read(w[20:16]);
                    p4   = pc + 32'd4;
                    npc  = p4;
                    boff = {{14{w[15]}}, w[15:0], 2'b00};
                    case (op)
                        OP_SPECIAL: begin
                            case (fn)
                                FN_ADD: begin
                                    r.wr = 1'b1; r.widx = w[15:11]; r.wval = a + b;
                                end
                                FN_SRL: begin
                                    r.wr = 1'b1; r.widx = w[15:11]; r.wval = b >> w[10:6];
                                end
                                FN_SLL: begin
                                    r.wr = 1'b1; r.widx = w[15:11]; r.wval = b << w[10:6];
                                end
                                FN_JR: npc = a;
                                default: ;
                            endcase
                        end
                        OP_ADDI: begin
                            r.wr   = 1'b1;
                            r.widx = w[20:16];
                            r.wval = a + {{16{w[15]}}, w[15:0]};
                        end
                        OP_ANDI: begin
                            r.wr   = 1'b1;
                            r.widx = w[20:16];
                            r.wval = a & {16'h0000, w[15:0]};
                        end
                        OP_BLEZ: if ($signed(a) <= 0) npc = p4 + boff;
                        OP_BNE:  if (a != b) npc = p4 + boff;
                        OP_JAL: begin
                            r.wr   = 1'b1;
                            r.widx = LINK_REG;
                            r.wval = p4;
                            npc    = {p4[31:28], w[25:0], 2'b00};
                        end
                        default: ;
                    endcase
                    // r0 is hardwired: drop the write entirely
                    if (r.wr && r.widx == ZERO_REG) begin
                        r.wr   = 1'b0;
                        r.widx = '0;
                        r.wval = '0;
                    end
                    if (r.wr) gpr[r.widx] = r.wval;
                    pc = npc;
                end
                REQ_READ:  r.rval = gpr_read(ridx);
                REQ_START: pc = start_addr;
                default: ;
            endcase
            r.npc = pc;
            pending_results.push_back(r);
        endfunction

        task report(string what);
            if (fails < 40) $display("%0t ns  MISMATCH  %s", $realtime, what);
            fails++;
        endtask

        task check_result(t_word npc, logic wr, t_ridx widx, t_word wval, t_word rval);
            t_res exp;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result beat, next_pc %h", npc));
                return;
            end
            exp = pending_results.pop_front();
            if (npc !== exp.npc)
                report($sformatf("next_pc %h, expected %h", npc, exp.npc));
            if (wr !== exp.wr)
                report($sformatf("reg_written %b, expected %b", wr, exp.wr));
            if (widx !== exp.widx)
                report($sformatf("dest_index %0d, expected %0d", widx, exp.widx));
            if (wval !== exp.wval)
                report($sformatf("dest_value %h, expected %h", wval, exp.wval));
            if (rval !== exp.rval)
                report($sformatf("read_value %h, expected %h", rval, exp.rval));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_instr_word;
    logic [4:0]  i_read_index;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_next_pc;
    logic        o_reg_written;
    logic [4:0]  o_dest_index;
    logic [31:0] o_dest_value;
    logic [31:0] o_read_value;

    exec_scoreboard sb;
    bit             send_gaps;
    bit             stall_bursts;

    mips_subset_instruction_executor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_instr_word  (i_instr_word),
        .i_read_index  (i_read_index),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_next_pc     (o_next_pc),
        .o_reg_written (o_reg_written),
        .o_dest_index  (o_dest_index),
        .o_dest_value  (o_dest_value),
        .o_read_value  (o_read_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

    // Sampled before this edge's updates land, so no race with the drivers.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall)
            sb.note_request(i_req_type, i_instr_word, i_read_index);
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_next_pc, o_reg_written, o_dest_index, o_dest_value,
                            o_read_value);
    end

    // Result side back-pressure in random bursts.
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n);
        forever begin
            if (stall_bursts && $urandom_range(0, 2) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    end

    function automatic t_word enc_r(t_ridx rs, t_ridx rt, t_ridx rd, logic [4:0] sa,
                                    logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic t_word enc_i(logic [5:0] op, t_ridx rs, t_ridx rt,
                                    logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Present one request beat and hold it until accepted. valid stays high
    // on return; the next beat or an explicit drop takes it from there.
    task automatic send_beat(logic [1:0] req, t_word w, t_ridx ridx);
        if (send_gaps && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_instr_word <= w;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // step past the calling edge first, so the beat accepted on it is queued
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    // start_address only changes with nothing in flight
    task automatic set_start_address(t_word addr);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= addr;
        sb.start_addr  = addr;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [1:0] req;
        t_word      w;
        t_ridx      rs;
        t_ridx      rt;
        t_ridx      rd;
        int         pick;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        i_req_type    <= REQ_EXEC;
        i_instr_word  <= '0;
        i_read_index  <= '0;
        sb            = new();
        send_gaps     = 1'b1;
        stall_bursts  = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every opcode, corner cases
        send_beat(REQ_READ, '0, ZERO_REG);
        send_beat(REQ_START, '1, '0);                          // reset start address
        send_beat(REQ_EXEC, enc_i(OP_ADDI, 5'd0, 5'd1, 16'h7FFF), '1);
        send_beat(REQ_EXEC, enc_i(OP_ADDI, 5'd0, 5'd2, 16'h8000), '0);
        send_beat(REQ_EXEC, enc_r(5'd1, 5'd2, 5'd3, 5'd31, FN_ADD), '0);  // shamt ignored
        send_beat(REQ_EXEC, enc_r(5'd9, 5'd1, 5'd4, 5'd31, FN_SLL), '0);
        send_beat(REQ_EXEC, enc_r(5'd0, 5'd2, 5'd5, 5'd31, FN_SRL), '0);
        send_beat(REQ_EXEC, enc_i(OP_ANDI, 5'd2, 5'd6, 16'hFFFF), '0);   // zero-extended
        send_beat(REQ_EXEC, enc_i(OP_ADDI, 5'd1, 5'd0, 16'h1234), '0);   // r0 write dropped
        send_beat(REQ_EXEC, '0, '0);                                      // nop
        send_beat(REQ_EXEC, enc_r(5'd4, 5'd4, 5'd7, 5'd0, FN_ADD), '0);  // wraps to zero
        send_beat(REQ_EXEC, enc_i(OP_BLEZ, 5'd2, 5'd0, 16'hFFFF), '0);   // negative: taken
        send_beat(REQ_EXEC, enc_i(OP_BLEZ, 5'd0, 5'd0, 16'h7FFF), '0);   // zero: taken
        send_beat(REQ_EXEC, enc_i(OP_BLEZ, 5'd1, 5'd0, 16'h8000), '0);   // positive
        send_beat(REQ_EXEC, enc_i(OP_BNE, 5'd1, 5'd2, 16'h8000), '0);
        send_beat(REQ_EXEC, enc_i(OP_BNE, 5'd3, 5'd3, 16'h0001), '0);
        send_beat(REQ_EXEC, {OP_JAL, 26'h3FF_FFFF}, '0);
        send_beat(REQ_EXEC, enc_i(OP_ADDI, 5'd0, 5'd8, 16'h0003), '0);
        send_beat(REQ_EXEC, enc_r(5'd8, 5'd31, 5'd31, 5'd31, FN_JR), '0); // unaligned jump
        send_beat(REQ_EXEC, 32'hFFFF_FFFF, '0);                           // unknown opcode
        send_beat(REQ_EXEC, enc_r(5'd1, 5'd2, 5'd3, 5'd0, FN_UNUSED), '0);
        send_beat(REQ_READ, '0, LINK_REG);
        send_beat(REQ_NONE, '1, '1);
        send_beat(REQ_START, '0, '0);

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       set_start_address(32'hFFFF_FFFC);
                1:       set_start_address(32'h0000_0000);
                2:       set_start_address(32'h0000_0003);
                default: set_start_address($urandom_range(32'hFFFF_FFFC));
            endcase
            if (phase == 7) begin
                send_gaps    = 1'b0;
                stall_bursts = 1'b0;
            end
            send_beat(REQ_START, $urandom, t_ridx'($urandom));
            for (int n = 0; n < 128; n++) begin
                pick = $urandom_range(0, 99);
                req  = (pick < 80) ? REQ_EXEC : (pick < 93) ? REQ_READ :
                       (pick < 98) ? REQ_START : REQ_NONE;
                w    = $urandom;
                if (req == REQ_EXEC) begin
                    // low registers most of the time so results feed later beats
                    rs = ($urandom_range(0, 4) == 0) ? t_ridx'($urandom)
                                                      : t_ridx'($urandom_range(0, 7));
                    rt = ($urandom_range(0, 4) == 0) ? t_ridx'($urandom)
                                                      : t_ridx'($urandom_range(0, 7));
                    rd = ($urandom_range(0, 4) == 0) ? t_ridx'($urandom)
                                                      : t_ridx'($urandom_range(0, 7));
                    case ($urandom_range(0, 11))
                        0, 1: w = enc_r(rs, rt, rd, w[10:6], FN_ADD);
                        2:    w = enc_r(w[25:21], rt, rd, w[10:6], FN_SLL);
                        3:    w = enc_r(w[25:21], rt, rd, w[10:6], FN_SRL);
                        4:    w = enc_r(rs, w[20:16], w[15:11], w[10:6], FN_JR);
                        5, 6: w = enc_i(OP_ADDI, rs, rt, w[15:0]);
                        7:    w = enc_i(OP_ANDI, rs, rt, w[15:0]);
                        8:    w = enc_i(OP_BLEZ, rs, w[20:16], w[15:0]);
                        9:    w = enc_i(OP_BNE, rs, rt, w[15:0]);
                        10:   w = {OP_JAL, w[25:0]};
                        default: ;  // raw word, mostly unknown encodings
                    endcase
                end
                send_beat(req, w, t_ridx'($urandom));
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
